FILE: design/fdtd_pkg.sv
// Package for the 1-D FDTD step unit: widths, request codes, fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps
package fdtd_pkg;
	localparam int CELLS     = 1024;
	localparam int FRAC_BITS = 24;
	localparam int IDX_W     = $clog2(CELLS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int NUM_CFG   = 5;

	typedef enum logic [1:0] {
		REQ_WRITE_CELL = 2'd0,
		REQ_WRITE_PML  = 2'd1,
		REQ_RUN_STEP   = 2'd2,
		REQ_READ_CELL  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_E_STEP     = 3'd0,
		CFG_H_STEP     = 3'd1,
		CFG_INV_DZ     = 3'd2,
		CFG_TIME_STEP  = 3'd3,
		CFG_SOURCE_POS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] v;
		logic        sat;
	} sat_t;

	function automatic sat_t clamp33(input logic signed [32:0] x);
		sat_t r;
		r.sat = (x[32] != x[31]);
		r.v   = r.sat ? (x[32] ? 32'h8000_0000 : 32'h7fff_ffff) : x[31:0];
		return r;
	endfunction

	function automatic sat_t add_sat(input logic signed [31:0] a, input logic signed [31:0] b);
		return clamp33(33'(a) + 33'(b));
	endfunction

	function automatic sat_t sub_sat(input logic signed [31:0] a, input logic signed [31:0] b);
		return clamp33(33'(a) - 33'(b));
	endfunction

	// Round a 64-bit product to nearest, ties up, then saturate.
	function automatic sat_t round_sat(input logic signed [63:0] p);
		logic signed [64:0] q;
		logic signed [64:0] s;
		sat_t r;
		q = 65'(p) + (65'sd1 <<< (FRAC_BITS - 1));
		s = q >>> FRAC_BITS;
		r.sat = (s > 65'sd2147483647) || (s < -65'sd2147483648);
		r.v   = (s > 65'sd2147483647) ? 32'h7fff_ffff :
			(s < -65'sd2147483648) ? 32'h8000_0000 : s[31:0];
		return r;
	endfunction
endpackage

FILE: design/fdtd_if.sv
// Valid/ready channel interfaces for the FDTD step unit.
// Depends on fdtd_pkg.
`timescale 1ns / 1ps
interface fdtd_req_if import fdtd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [IDX_W-1:0]   cell_index;
	logic signed [31:0] ex_in, hy_in, aux_e_in, aux_h_in, potential_in;
	logic signed [31:0] pml_b_e, pml_g_e, pml_b_h, pml_g_h, source_value;
	modport source (output valid, req_type, cell_index, ex_in, hy_in, aux_e_in, aux_h_in,
		potential_in, pml_b_e, pml_g_e, pml_b_h, pml_g_h, source_value, input ready);
	modport sink (input valid, req_type, cell_index, ex_in, hy_in, aux_e_in, aux_h_in,
		potential_in, pml_b_e, pml_g_e, pml_b_h, pml_g_h, source_value, output ready);
endinterface

interface fdtd_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ex_out, hy_out, aux_e_out, aux_h_out, potential_out, old_potential_out;
	logic               saturated;
	logic               step_done;
	modport source (output valid, ex_out, hy_out, aux_e_out, aux_h_out, potential_out,
		old_potential_out, saturated, step_done, input ready);
	modport sink (input valid, ex_out, hy_out, aux_e_out, aux_h_out, potential_out,
		old_potential_out, saturated, step_done, output ready);
endinterface

interface fdtd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/fdtd_1d_cpml_step_unit.sv
// Top level of the 1-D Yee FDTD engine with CPML boundary.
// Depends on fdtd_pkg and the channel interfaces in fdtd_if.sv.
`timescale 1ns / 1ps
//
// channel | dir | handshake     | carries
// req     | in  | valid/ready   | request type, cell index, write data, source sample
// rsp     | out | valid/ready   | read-back fields, saturated, step_done
// cfg     | in  | valid/ready   | register index, 32-bit write data
//
// After reset a clearing pass zeroes every memory; no request is taken during it.
// A write result reaches the output register through ST_RESP, a read result through
// ST_RD and ST_RD_OUT. A step request takes each E and H sweep cell through the RD,
// LD, T, M1, M2, M3 and WR states and each potential sweep cell through RD, M and WR,
// as every product of a cell goes through the single shared 32x32 multiplier.
// Reset clears control state only. A result waits in the output register until taken;
// ready stays low while a request runs and while its result waits.
module fdtd_1d_cpml_step_unit import fdtd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fdtd_req_if.sink   req,
	fdtd_rsp_if.source rsp,
	fdtd_cfg_if.sink   cfg
);
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_RD_OUT, ST_SRC_RD, ST_SRC_WR,
		ST_E_RD, ST_E_LD, ST_E_T, ST_E_M1, ST_E_M2, ST_E_M3, ST_E_WR,
		ST_H_RD, ST_H_LD, ST_H_T, ST_H_M1, ST_H_M2, ST_H_M3, ST_H_WR,
		ST_P_RD, ST_P_M, ST_P_WR, ST_RESP
	} state_t;

	// Memories: one write and up to two registered reads each cycle.
	logic [31:0] e_mem [CELLS];
	logic [31:0] h_mem [CELLS];
	logic [31:0] ae_mem [CELLS];
	logic [31:0] ah_mem [CELLS];
	logic [31:0] p_mem [CELLS];
	logic [31:0] op_mem [CELLS];
	logic [63:0] ce_mem [CELLS];
	logic [63:0] ch_mem [CELLS];

	state_t state_q;
	logic [CNT_W-1:0] k_q;
	logic [IDX_W-1:0] ra_q;
	logic [31:0] e_step_q, h_step_q, inv_dz_q, time_step_q;
	logic [IDX_W-1:0] src_pos_q;
	logic [31:0] src_q;
	logic [1:0] rtype_q;
	logic [IDX_W-1:0] idx_q;
	logic sat_q;

	// Read data registers.
	logic [31:0] e0_rd, e1_rd, h0_rd, h1_rd, ae_rd, ah_rd, p_rd, op_rd;
	logic [63:0] ce_rd, ch_rd;
	// Working registers.
	logic [31:0] w0_q, w1_q, t_q, aux_q, acc_q;

	// Memory controls from the sequencer.
	logic        we_e, we_h, we_ae, we_ah, we_p, we_op, we_ce, we_ch;
	logic [IDX_W-1:0] wa;
	logic [31:0] wd_e, wd_h, wd_ae, wd_ah, wd_p, wd_op;
	logic [63:0] wd_ce, wd_ch;
	logic [IDX_W-1:0] ra0, ra1;

	// Shared multiplier.
	logic signed [31:0] ma, mb;
	sat_t mres;
	assign mres = round_sat($signed(ma) * $signed(mb));

	always_ff @(posedge clk) begin
		if (we_e)  e_mem[wa]  <= wd_e;
		if (we_h)  h_mem[wa]  <= wd_h;
		if (we_ae) ae_mem[wa] <= wd_ae;
		if (we_ah) ah_mem[wa] <= wd_ah;
		if (we_p)  p_mem[wa]  <= wd_p;
		if (we_op) op_mem[wa] <= wd_op;
		if (we_ce) ce_mem[wa] <= wd_ce;
		if (we_ch) ch_mem[wa] <= wd_ch;
		e0_rd <= e_mem[ra0];
		e1_rd <= e_mem[ra1];
		h0_rd <= h_mem[ra0];
		h1_rd <= h_mem[ra1];
		ae_rd <= ae_mem[ra0];
		ah_rd <= ah_mem[ra0];
		p_rd  <= p_mem[ra0];
		op_rd <= op_mem[ra0];
		ce_rd <= ce_mem[ra0];
		ch_rd <= ch_mem[ra0];
	end

	localparam logic [CNT_W-1:0] LAST = CNT_W'(CELLS - 1);
	logic [IDX_W-1:0] k_i;
	assign k_i = k_q[IDX_W-1:0];

	sat_t d_s, s1, s2, s3;

	// Datapath combinational picks: the sequencer reuses one multiplier for every product.
	always_comb begin
		we_e = 1'b0; we_h = 1'b0; we_ae = 1'b0; we_ah = 1'b0;
		we_p = 1'b0; we_op = 1'b0; we_ce = 1'b0; we_ch = 1'b0;
		wa = k_i;
		wd_e = '0; wd_h = '0; wd_ae = '0; wd_ah = '0; wd_p = '0; wd_op = '0;
		wd_ce = '0; wd_ch = '0;
		ra0 = ra_q; ra1 = ra_q;
		// Hold the read port on the current cell for the whole sweep.
		if (state_q >= ST_E_RD && state_q <= ST_P_WR)
			ra0 = k_i;
		ma = '0; mb = '0;
		d_s = '0; s1 = '0; s2 = '0; s3 = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we_e = 1'b1; we_h = 1'b1; we_ae = 1'b1; we_ah = 1'b1;
				we_p = 1'b1; we_op = 1'b1; we_ce = 1'b1; we_ch = 1'b1;
			end
			ST_IDLE: begin
				wa = req.cell_index;
				if (req.valid && !rsp.valid) begin
					if (req.req_type == REQ_WRITE_CELL) begin
						we_e = 1'b1; we_ae = 1'b1; we_p = 1'b1;
						we_h = (req.cell_index != IDX_W'(CELLS - 1));
						we_ah = we_h;
					end else if (req.req_type == REQ_WRITE_PML) begin
						we_ce = 1'b1;
						we_ch = (req.cell_index != IDX_W'(CELLS - 1));
					end
				end
				wd_e = req.ex_in; wd_h = req.hy_in; wd_ae = req.aux_e_in;
				wd_ah = req.aux_h_in; wd_p = req.potential_in;
				wd_ce = {req.pml_g_e, req.pml_b_e};
				wd_ch = {req.pml_g_h, req.pml_b_h};
			end
			ST_SRC_WR: begin
				wa = src_pos_q;
				d_s = add_sat(e0_rd, src_q);
				wd_e = d_s.v; we_e = 1'b1;
			end
			ST_E_RD, ST_H_RD, ST_P_RD: begin
				ra0 = k_i;
				ra1 = (state_q == ST_H_RD) ? IDX_W'(k_q + 1'b1) : IDX_W'(k_q - 1'b1);
			end
			ST_E_T, ST_H_T: begin
				d_s = sub_sat(w0_q, w1_q);
				ma = d_s.v; mb = inv_dz_q;
			end
			ST_E_M1, ST_H_M1: begin
				ma = w0_q; mb = w1_q;
			end
			ST_E_M2, ST_H_M2: begin
				ma = w0_q; mb = t_q;
				s1 = sub_sat(acc_q, mres.v);
			end
			ST_E_M3, ST_H_M3: begin
				s2 = add_sat(t_q, aux_q);
				ma = (state_q == ST_E_M3) ? e_step_q : h_step_q;
				mb = s2.v;
				s3 = sub_sat(w0_q, mres.v);
			end
			ST_E_WR: begin
				wd_e = acc_q; wd_ae = aux_q; we_e = 1'b1; we_ae = 1'b1;
			end
			ST_H_WR: begin
				wd_h = acc_q; wd_ah = aux_q; we_h = 1'b1; we_ah = 1'b1;
			end
			ST_P_M: begin
				ma = time_step_q; mb = e0_rd;
				s1 = sub_sat(p_rd, mres.v);
			end
			ST_P_WR: begin
				wd_p = acc_q; wd_op = w1_q; we_p = 1'b1; we_op = 1'b1;
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE) && !rsp.valid;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q <= '0;
			e_step_q <= '0; h_step_q <= '0; time_step_q <= '0;
			inv_dz_q <= 32'(1) << FRAC_BITS;
			src_pos_q <= '0;
			rsp.valid <= 1'b0;
			rsp.ex_out <= '0; rsp.hy_out <= '0; rsp.aux_e_out <= '0;
			rsp.aux_h_out <= '0; rsp.potential_out <= '0; rsp.old_potential_out <= '0;
			rsp.saturated <= 1'b0; rsp.step_done <= 1'b0;
			sat_q <= 1'b0;
			ra_q <= '0; rtype_q <= '0; idx_q <= '0; src_q <= '0;
			w0_q <= '0; w1_q <= '0; t_q <= '0; aux_q <= '0; acc_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_E_STEP:     e_step_q <= cfg.data;
					CFG_H_STEP:     h_step_q <= cfg.data;
					CFG_INV_DZ:     inv_dz_q <= cfg.data;
					CFG_TIME_STEP:  time_step_q <= cfg.data;
					CFG_SOURCE_POS: src_pos_q <= cfg.data[IDX_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req.valid && !rsp.valid) begin
						rtype_q <= req.req_type;
						idx_q <= req.cell_index;
						ra_q <= req.cell_index;
						src_q <= req.source_value;
						sat_q <= 1'b0;
						unique case (req_t'(req.req_type))
							REQ_READ_CELL: state_q <= ST_RD;
							REQ_RUN_STEP: begin
								ra_q <= src_pos_q;
								state_q <= ST_SRC_RD;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_RD: state_q <= ST_RD_OUT;
				ST_RD_OUT: begin
					rsp.ex_out <= e0_rd; rsp.aux_e_out <= ae_rd;
					rsp.potential_out <= p_rd; rsp.old_potential_out <= op_rd;
					rsp.hy_out <= (idx_q == IDX_W'(CELLS - 1)) ? '0 : h0_rd;
					rsp.aux_h_out <= (idx_q == IDX_W'(CELLS - 1)) ? '0 : ah_rd;
					rsp.saturated <= 1'b0; rsp.step_done <= 1'b0;
					rsp.valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SRC_RD: state_q <= ST_SRC_WR;
				ST_SRC_WR: begin
					sat_q <= d_s.sat;
					k_q <= CNT_W'(1);
					state_q <= ST_E_RD;
				end
				// E sweep over interior cells, old H.
				ST_E_RD: state_q <= ST_E_LD;
				ST_E_LD: begin
					w0_q <= h0_rd; w1_q <= h1_rd;
					state_q <= ST_E_T;
				end
				ST_E_T: begin
					t_q <= mres.v; sat_q <= sat_q | d_s.sat | mres.sat;
					w0_q <= ce_rd[31:0]; w1_q <= ae_rd;
					state_q <= ST_E_M1;
				end
				ST_E_M1: begin
					acc_q <= mres.v; sat_q <= sat_q | mres.sat;
					w0_q <= ce_rd[63:32];
					state_q <= ST_E_M2;
				end
				ST_E_M2: begin
					aux_q <= s1.v; sat_q <= sat_q | mres.sat | s1.sat;
					w0_q <= e0_rd;
					state_q <= ST_E_M3;
				end
				ST_E_M3: begin
					acc_q <= s3.v; sat_q <= sat_q | s2.sat | mres.sat | s3.sat;
					state_q <= ST_E_WR;
				end
				ST_E_WR: begin
					if (k_q == LAST - 1'b1) begin
						k_q <= '0; state_q <= ST_H_RD;
					end else begin
						k_q <= k_q + 1'b1; state_q <= ST_E_RD;
					end
				end
				// H sweep over all H cells, new E.
				ST_H_RD: state_q <= ST_H_LD;
				ST_H_LD: begin
					w0_q <= e1_rd; w1_q <= e0_rd;
					state_q <= ST_H_T;
				end
				ST_H_T: begin
					t_q <= mres.v; sat_q <= sat_q | d_s.sat | mres.sat;
					w0_q <= ch_rd[31:0]; w1_q <= ah_rd;
					state_q <= ST_H_M1;
				end
				ST_H_M1: begin
					acc_q <= mres.v; sat_q <= sat_q | mres.sat;
					w0_q <= ch_rd[63:32];
					state_q <= ST_H_M2;
				end
				ST_H_M2: begin
					aux_q <= s1.v; sat_q <= sat_q | mres.sat | s1.sat;
					w0_q <= h0_rd;
					state_q <= ST_H_M3;
				end
				ST_H_M3: begin
					acc_q <= s3.v; sat_q <= sat_q | s2.sat | mres.sat | s3.sat;
					state_q <= ST_H_WR;
				end
				ST_H_WR: begin
					if (k_q == LAST - 1'b1) begin
						k_q <= CNT_W'(1); state_q <= ST_P_RD;
					end else begin
						k_q <= k_q + 1'b1; state_q <= ST_H_RD;
					end
				end
				// Potential sweep: save old, subtract dt*E.
				ST_P_RD: state_q <= ST_P_M;
				ST_P_M: begin
					acc_q <= s1.v; sat_q <= sat_q | mres.sat | s1.sat;
					w1_q <= p_rd;
					state_q <= ST_P_WR;
				end
				ST_P_WR: begin
					if (k_q == LAST - 1'b1) state_q <= ST_RESP;
					else begin
						k_q <= k_q + 1'b1; state_q <= ST_P_RD;
					end
				end
				ST_RESP: begin
					rsp.ex_out <= '0; rsp.hy_out <= '0; rsp.aux_e_out <= '0;
					rsp.aux_h_out <= '0; rsp.potential_out <= '0;
					rsp.old_potential_out <= '0;
					rsp.step_done <= (rtype_q == REQ_RUN_STEP);
					rsp.saturated <= (rtype_q == REQ_RUN_STEP) && sat_q;
					rsp.valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: test/fdtd_1d_cpml_step_unit_checker.sv
// Checker for the 1-D FDTD step unit: tracks the grid state, predicts every response.
// Depends on fdtd_pkg and the channel interfaces in design/fdtd_if.sv.
`timescale 1ns / 1ps
module fdtd_1d_cpml_step_unit_checker import fdtd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fdtd_req_if  req,
	fdtd_rsp_if  rsp,
	fdtd_cfg_if  cfg,
	output int   errors,
	output int   pending
);
	typedef struct {
		int ex, hy, aux_e, aux_h, pot, old_pot;
		bit sat, done;
	} readback_t;

	int e_grid[CELLS];
	int h_grid[CELLS];
	int aux_e_grid[CELLS];
	int aux_h_grid[CELLS];
	int pot_grid[CELLS];
	int old_pot_grid[CELLS];
	int b_e[CELLS], g_e[CELLS], b_h[CELLS], g_h[CELLS];
	int e_step, h_step, inv_dz, dt;
	int src_cell;
	bit step_sat;
	readback_t expected_readback[$];

	assign pending = expected_readback.size();

	initial begin
		errors = 0;
		for (int i = 0; i < CELLS; i++) begin
			e_grid[i] = 0; h_grid[i] = 0; aux_e_grid[i] = 0; aux_h_grid[i] = 0;
			pot_grid[i] = 0; old_pot_grid[i] = 0;
			b_e[i] = 0; g_e[i] = 0; b_h[i] = 0; g_h[i] = 0;
		end
		e_step = 0; h_step = 0; dt = 0; src_cell = 0;
		inv_dz = 1 << FRAC_BITS;
	end

	function automatic int clip(longint v);
		if (v > 64'sd2147483647) begin
			step_sat = 1;
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			step_sat = 1;
			return 32'h8000_0000;
		end
		return int'(v);
	endfunction

	// Round to nearest with ties up: arithmetic shift of a signed value is a floor.
	function automatic int qmul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
		return clip(p >>> FRAC_BITS);
	endfunction

	function automatic int qadd(int a, int b);
		return clip(longint'(a) + longint'(b));
	endfunction

	function automatic int qsub(int a, int b);
		return clip(longint'(a) - longint'(b));
	endfunction

	function automatic void advance_grid(int src);
		int t;
		if (src_cell < CELLS)
			e_grid[src_cell] = qadd(e_grid[src_cell], src);
		// E from old H
		for (int k = 1; k < CELLS - 1; k++) begin
			t = qmul(qsub(h_grid[k], h_grid[k-1]), inv_dz);
			aux_e_grid[k] = qsub(qmul(b_e[k], aux_e_grid[k]), qmul(g_e[k], t));
			e_grid[k] = qsub(e_grid[k], qmul(e_step, qadd(t, aux_e_grid[k])));
		end
		// H from new E
		for (int k = 0; k < CELLS - 1; k++) begin
			t = qmul(qsub(e_grid[k+1], e_grid[k]), inv_dz);
			aux_h_grid[k] = qsub(qmul(b_h[k], aux_h_grid[k]), qmul(g_h[k], t));
			h_grid[k] = qsub(h_grid[k], qmul(h_step, qadd(t, aux_h_grid[k])));
		end
		for (int k = 1; k < CELLS - 1; k++) begin
			old_pot_grid[k] = pot_grid[k];
			pot_grid[k] = qsub(pot_grid[k], qmul(dt, e_grid[k]));
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		readback_t r, w;
		int idx;
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_E_STEP:     e_step = cfg.data;
				CFG_H_STEP:     h_step = cfg.data;
				CFG_INV_DZ:     inv_dz = cfg.data;
				CFG_TIME_STEP:  dt = cfg.data;
				CFG_SOURCE_POS: src_cell = cfg.data[IDX_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && req.valid && req.ready) begin
			r = '{default: 0};
			idx = req.cell_index;
			case (req_t'(req.req_type))
				REQ_WRITE_CELL: begin
					e_grid[idx] = req.ex_in;
					aux_e_grid[idx] = req.aux_e_in;
					pot_grid[idx] = req.potential_in;
					if (idx < CELLS - 1) begin
						h_grid[idx] = req.hy_in;
						aux_h_grid[idx] = req.aux_h_in;
					end
				end
				REQ_WRITE_PML: begin
					b_e[idx] = req.pml_b_e;
					g_e[idx] = req.pml_g_e;
					if (idx < CELLS - 1) begin
						b_h[idx] = req.pml_b_h;
						g_h[idx] = req.pml_g_h;
					end
				end
				REQ_RUN_STEP: begin
					step_sat = 0;
					advance_grid(req.source_value);
					r.sat = step_sat;
					r.done = 1;
				end
				default: begin
					r.ex = e_grid[idx];
					r.aux_e = aux_e_grid[idx];
					r.pot = pot_grid[idx];
					r.old_pot = old_pot_grid[idx];
					if (idx < CELLS - 1) begin
						r.hy = h_grid[idx];
						r.aux_h = aux_h_grid[idx];
					end
				end
			endcase
			expected_readback.push_back(r);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_readback.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				w = expected_readback.pop_front();
				check_field("ex_out", w.ex, rsp.ex_out);
				check_field("hy_out", w.hy, rsp.hy_out);
				check_field("aux_e_out", w.aux_e, rsp.aux_e_out);
				check_field("aux_h_out", w.aux_h, rsp.aux_h_out);
				check_field("potential_out", w.pot, rsp.potential_out);
				check_field("old_potential_out", w.old_pot, rsp.old_potential_out);
				check_field("saturated", w.sat, rsp.saturated);
				check_field("step_done", w.done, rsp.step_done);
			end
		end
	end
endmodule

FILE: test/fdtd_1d_cpml_step_unit_test.sv
// Top of the FDTD step unit testbench: clock, reset, requests, register writes, verdict.
// Depends on fdtd_pkg, design/fdtd_if.sv, the step unit and its checker.
`timescale 1ns / 1ps
module fdtd_1d_cpml_step_unit_test;
	import fdtd_pkg::*;

	typedef struct {
		req_t kind;
		int   cell_no;
		int   ex, hy, aux_e, aux_h, pot;
		int   be, ge, bh, gh;
		int   src;
	} grid_req_t;

	// A step runs with no handshake, so STALL_LIMIT lies well above its length and a
	// silent stretch that reaches it still means a hang.
	localparam int STALL_LIMIT = 400000;
	localparam int ONE = 1 << FRAC_BITS;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   quiet_cycles;
	bit   calm;

	fdtd_req_if req ();
	fdtd_rsp_if rsp ();
	fdtd_cfg_if cfg ();

	fdtd_1d_cpml_step_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	fdtd_1d_cpml_step_unit_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// After about 15 requests in a hundred, idle for a random gap, except in the calm stretch.
	function automatic int gap_len();
		if (calm || $urandom_range(99) >= 15)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	// Response backpressure runs on its own.
	always @(posedge clk) begin
		rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
	end

	// Watchdog: count cycles in which no handshake completes.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Drive one request and hold it until taken. Valid stays high on return, so the
	// caller either chains the next request in the same step or drops valid.
	task automatic issue(input grid_req_t it);
		req.valid <= 1'b1;
		req.req_type <= it.kind;
		req.cell_index <= it.cell_no[IDX_W-1:0];
		req.ex_in <= it.ex;
		req.hy_in <= it.hy;
		req.aux_e_in <= it.aux_e;
		req.aux_h_in <= it.aux_h;
		req.potential_in <= it.pot;
		req.pml_b_e <= it.be;
		req.pml_g_e <= it.ge;
		req.pml_b_h <= it.bh;
		req.pml_g_h <= it.gh;
		req.source_value <= it.src;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic send(input grid_req_t it);
		int n;
		issue(it);
		n = gap_len();
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Park the request side and hold off until every response is back.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input int es, input int hs, input int dz, input int ts,
		input int sp);
		write_reg(CFG_E_STEP, es);
		write_reg(CFG_H_STEP, hs);
		write_reg(CFG_INV_DZ, dz);
		write_reg(CFG_TIME_STEP, ts);
		write_reg(CFG_SOURCE_POS, sp);
	endtask

	// Mostly modest values so the fields evolve; some full-range and extreme ones.
	function automatic int pick_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return $urandom_range(0, 2 * ONE) - ONE;
		endcase
	endfunction

	// Coefficients near the decay range of a real absorbing layer.
	function automatic int pick_coef();
		if ($urandom_range(9) == 0)
			return pick_value();
		return $urandom_range(0, ONE);
	endfunction

	// Cluster cells around the source window and the grid ends.
	function automatic int pick_cell();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 15);
			6, 7: return $urandom_range(CELLS - 6, CELLS - 1);
			default: return $urandom_range(0, CELLS - 1);
		endcase
	endfunction

	function automatic grid_req_t make_req(input req_t kind, input int cell_no);
		grid_req_t it;
		it.kind = kind;
		it.cell_no = cell_no;
		it.ex = pick_value();
		it.hy = pick_value();
		it.aux_e = pick_value();
		it.aux_h = pick_value();
		it.pot = pick_value();
		it.be = pick_coef();
		it.ge = pick_coef();
		it.bh = pick_coef();
		it.gh = pick_coef();
		it.src = pick_value();
		return it;
	endfunction

	task automatic random_burst(input int count);
		grid_req_t it;
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 12)
				it = make_req(REQ_RUN_STEP, pick_cell());
			else if (roll < 45)
				it = make_req(REQ_WRITE_CELL, pick_cell());
			else if (roll < 60)
				it = make_req(REQ_WRITE_PML, pick_cell());
			else
				it = make_req(REQ_READ_CELL, pick_cell());
			send(it);
		end
	endtask

	initial begin
		grid_req_t it;
		arst_n = 1'b0;
		calm = 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_WRITE_CELL;
		req.cell_index <= '0;
		req.ex_in <= 0;
		req.hy_in <= 0;
		req.aux_e_in <= 0;
		req.aux_h_in <= 0;
		req.potential_in <= 0;
		req.pml_b_e <= 0;
		req.pml_g_e <= 0;
		req.pml_b_h <= 0;
		req.pml_g_h <= 0;
		req.source_value <= 0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_E_STEP;
		cfg.data <= 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read untouched cells first, then exercise the grid ends.
		send(make_req(REQ_READ_CELL, 0));
		send(make_req(REQ_READ_CELL, CELLS - 1));
		drain();
		program_regs(ONE / 2, ONE / 2, ONE, ONE / 4, 5);

		it = make_req(REQ_WRITE_CELL, 0);
		it.ex = 32'h7fff_ffff; it.hy = 32'h8000_0000; it.aux_e = -1; it.aux_h = 1;
		it.pot = 32'h8000_0000;
		send(it);
		it = make_req(REQ_WRITE_CELL, CELLS - 1);
		it.ex = 32'h8000_0000; it.hy = 32'h7fff_ffff; it.aux_h = 32'h7fff_ffff;
		send(it);
		it = make_req(REQ_WRITE_CELL, CELLS - 2);
		it.ex = ONE; it.hy = -ONE;
		send(it);
		it = make_req(REQ_WRITE_PML, 1);
		it.be = ONE * 9 / 10; it.ge = ONE / 10; it.bh = ONE / 2; it.gh = ONE / 4;
		send(it);
		// the last cell has no H-side coefficients
		it = make_req(REQ_WRITE_PML, CELLS - 1);
		it.be = 32'h7fff_ffff; it.ge = 32'h8000_0000; it.bh = ONE; it.gh = ONE;
		send(it);
		send(make_req(REQ_READ_CELL, 0));
		send(make_req(REQ_READ_CELL, CELLS - 1));
		send(make_req(REQ_READ_CELL, CELLS - 2));

		it = make_req(REQ_RUN_STEP, 0);
		it.src = ONE;
		send(it);
		for (int c = 0; c < 3; c++)
			send(make_req(REQ_READ_CELL, 4 + c));
		send(make_req(REQ_READ_CELL, 1));

		// A source at the positive limit forces saturation at the source cell.
		it = make_req(REQ_RUN_STEP, 0);
		it.src = 32'h7fff_ffff;
		send(it);
		send(make_req(REQ_READ_CELL, 5));
		send(make_req(REQ_READ_CELL, CELLS - 1));
		drain();

		// Phase: extreme register values, source on the last cell.
		program_regs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			CELLS - 1);
		random_burst(30);
		drain();

		// Phase: calm stretch with both sides streaming, source on cell 0.
		program_regs(ONE / 8, ONE / 8, ONE, ONE / 16, 0);
		calm = 1'b1;
		random_burst(30);
		drain();
		calm = 1'b0;

		// Phase: random registers, full width.
		program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		random_burst(25);
		drain();

		// Phase: zero and negative extremes, source inside the dense window.
		program_regs(0, -ONE, 32'h8000_0000, 0, $urandom_range(0, 15));
		random_burst(15);
		drain();

		program_regs(ONE / 2, ONE / 2, ONE * 2, ONE / 4, $urandom_range(0, 15));
		random_burst(20);
		drain();

		// Let any trailing response settle before the verdict.
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
